// ===== rtl/rational_arithmetic_unit_macros.svh =====
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Opcodes, defaults and shared types for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned OperandWidthDef = 32;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_LT   = 4'd4,
    CMD_LE   = 4'd5,
    CMD_GT   = 4'd6,
    CMD_GE   = 4'd7,
    CMD_EQ   = 4'd8,
    CMD_NE   = 4'd9,
    CMD_RED  = 4'd10,
    CMD_CMPL = 4'd11,
    CMD_INC  = 4'd12,
    CMD_DEC  = 4'd13,
    CMD_NEG  = 4'd14,
    CMD_NONE = 4'd15
  } cmd_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rau_divider.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_divider
  import rau_pkg::*;
#(
  parameter int unsigned W = OperandWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {rem_q, quot_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Arithmetic, comparison and reduction on pairs of fractions.
// ----------------------------------------------------------------------------
// An operation word enters on the s_axis channel: an opcode and two fractions
// a and b. One result word leaves on the m_axis channel: a 64-bit numerator,
// a 63-bit denominator and a flag. The block handles one word at a time and
// drops s_axis_tready while it works. Products are built on one shared
// 32 by 32 multiplier, one product per cycle. For add, subtract and the
// comparisons the sequencer passes through MUL1, MUL2 and MUL3 before the
// result is valid in OUT; multiply and divide pass through MUL1 and MUL2,
// and add or subtract with equal denominators and the operations on a
// alone through MUL1 only. Reduce runs a Euclid loop on a shared
// one-bit-per-cycle divider, then two divisions if the gcd exceeds one.
// The result is held in an output register until m_axis_tready is high, and
// the block stays busy until then. s_axis_tready rises in the cycle after the
// result word is taken. Reset drops m_axis_tvalid and returns the sequencer
// to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // cmd[3:0], a_num[35:4], a_den[66:36], b_num[98:67], b_den[129:99], zeros
  input  wire logic [135:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // res_num[63:0], res_den[126:64], flag[127]
  output logic [127:0]       m_axis_tdata
);

  localparam int unsigned W = OPERAND_WIDTH;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_MUL2 = 7'b0000100,
    ST_MUL3 = 7'b0001000,
    ST_GCD  = 7'b0010000,
    ST_DIVS = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]         cmd_q, cmd_d;
  logic signed [63:0] an_q, an_d, bn_q, bn_d;
  logic [63:0]        ad_q, ad_d, bd_q, bd_d;
  logic [63:0]        p0_q, p0_d, p1_q, p1_d;
  logic [63:0]        rn_q, rn_d;
  logic [62:0]        rd_q, rd_d;
  logic               fl_q, fl_d, ov_q, ov_d;
  logic [W-1:0]       gx_q, gx_d, gy_q, gy_d, mag_q, mag_d;
  logic [1:0]         ph_q, ph_d;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic               eq_den;
  logic signed [63:0] lhs, rhs;

  logic               dv_start;
  logic [W-1:0]       dv_a, dv_b, dv_quot, dv_rem;
  logic               dv_busy, dv_done;
  div_ctrl_t          dv_ctrl;

  assign prod   = 64'(ma) * 64'(mb);
  assign eq_den = (ad_q == bd_q);
  assign lhs    = $signed(p0_q);
  assign rhs    = $signed(p1_q);

  assign dv_ctrl.start = dv_start;
  assign dv_ctrl.busy  = dv_busy;

  rau_divider #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_ctrl.start),
    .dividend_i (dv_a),
    .divisor_i  (dv_b),
    .busy_o     (dv_busy),
    .done_o     (dv_done),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem)
  );

  always_comb begin
    ma = an_q[31:0];
    mb = bd_q[31:0];
    case (state_q)
      ST_MUL1: begin
        case (cmd_q)
          CMD_MUL: begin ma = an_q[31:0]; mb = bn_q[31:0]; end
          default: begin ma = an_q[31:0]; mb = bd_q[31:0]; end
        endcase
      end
      ST_MUL2: begin
        case (cmd_q)
          CMD_MUL: begin ma = ad_q[31:0]; mb = bd_q[31:0]; end
          CMD_DIV: begin ma = ad_q[31:0]; mb = bn_q[31:0]; end
          default: begin ma = bn_q[31:0]; mb = ad_q[31:0]; end
        endcase
      end
      ST_MUL3: begin ma = ad_q[31:0]; mb = bd_q[31:0]; end
      default: begin ma = an_q[31:0]; mb = bd_q[31:0]; end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    an_d     = an_q;
    bn_d     = bn_q;
    ad_d     = ad_q;
    bd_d     = bd_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    rn_d     = rn_q;
    rd_d     = rd_q;
    fl_d     = fl_q;
    ov_d     = ov_q;
    gx_d     = gx_q;
    gy_d     = gy_q;
    mag_d    = mag_q;
    ph_d     = ph_q;
    dv_start = 1'b0;
    dv_a     = gx_q;
    dv_b     = gy_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tdata[3:0];
          an_d  = 64'($signed(s_axis_tdata[4 +: W]));
          ad_d  = 64'(s_axis_tdata[36 +: (W-1)]);
          bn_d  = 64'($signed(s_axis_tdata[67 +: W]));
          bd_d  = 64'(s_axis_tdata[99 +: (W-1)]);
          rn_d  = '0;
          rd_d  = '0;
          fl_d  = 1'b0;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        p0_d    = prod;
        state_d = ST_MUL2;
        case (cmd_q)
          CMD_RED: begin
            mag_d   = an_q[63] ? W'(-an_q) : W'(an_q);
            gx_d    = an_q[63] ? W'(-an_q) : W'(an_q);
            gy_d    = W'(ad_q);
            ph_d    = 2'd0;
            state_d = ST_GCD;
          end
          CMD_CMPL: begin
            if (an_q > $signed(ad_q)) begin
              rn_d = an_q;
            end else begin
              rn_d = ad_q - an_q;
            end
            rd_d    = ad_q[62:0];
            state_d = ST_OUT;
          end
          CMD_INC: begin
            rn_d = an_q + ad_q; rd_d = ad_q[62:0]; state_d = ST_OUT;
          end
          CMD_DEC: begin
            rn_d = an_q - ad_q; rd_d = ad_q[62:0]; state_d = ST_OUT;
          end
          CMD_NEG: begin
            rn_d = -an_q; rd_d = ad_q[62:0]; state_d = ST_OUT;
          end
          CMD_NONE: state_d = ST_OUT;
          CMD_ADD, CMD_SUB: begin
            if (eq_den) begin
              rn_d    = (cmd_q == CMD_ADD) ? an_q + bn_q : an_q - bn_q;
              rd_d    = ad_q[62:0];
              state_d = ST_OUT;
            end
          end
          default: ;
        endcase
      end
      ST_MUL2: begin
        p1_d = prod;
        case (cmd_q)
          CMD_MUL, CMD_DIV: begin
            rn_d = p0_q; rd_d = prod[62:0]; state_d = ST_OUT;
          end
          CMD_ADD, CMD_SUB: state_d = ST_MUL3;
          default: state_d = ST_MUL3;
        endcase
      end
      ST_MUL3: begin
        case (cmd_q)
          CMD_ADD: begin rn_d = p0_q + p1_q; rd_d = prod[62:0]; end
          CMD_SUB: begin rn_d = p0_q - p1_q; rd_d = prod[62:0]; end
          CMD_LT:  fl_d = (lhs < rhs);
          CMD_LE:  fl_d = (lhs <= rhs);
          CMD_GT:  fl_d = (lhs > rhs);
          CMD_GE:  fl_d = (lhs >= rhs);
          CMD_EQ:  fl_d = (lhs == rhs);
          CMD_NE:  fl_d = (lhs != rhs);
          default: ;
        endcase
        state_d = ST_OUT;
      end
      ST_GCD: begin
        if (ph_q == 2'd0) begin
          if (gy_q == '0) begin
            if (gx_q > W'(1)) begin
              ph_d    = 2'd0;
              state_d = ST_DIVS;
            end else begin
              rn_d    = an_q;
              rd_d    = ad_q[62:0];
              state_d = ST_OUT;
            end
          end else begin
            dv_start = 1'b1;
            ph_d     = 2'd1;
          end
        end else if (dv_done) begin
          gx_d = gy_q;
          gy_d = dv_rem;
          ph_d = 2'd0;
        end
      end
      ST_DIVS: begin
        case (ph_q)
          2'd0: begin
            dv_start = 1'b1; dv_a = mag_q; dv_b = gx_q; ph_d = 2'd1;
          end
          2'd1: begin
            if (dv_done) begin
              rn_d = an_q[63] ? -64'(dv_quot) : 64'(dv_quot);
              dv_start = 1'b1; dv_a = W'(ad_q); dv_b = gx_q; ph_d = 2'd2;
            end
          end
          default: begin
            if (dv_done) begin
              rd_d    = 63'(dv_quot);
              fl_d    = 1'b1;
              state_d = ST_OUT;
            end
          end
        endcase
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    an_q  <= an_d;
    bn_q  <= bn_d;
    ad_q  <= ad_d;
    bd_q  <= bd_d;
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    fl_q  <= fl_d;
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    mag_q <= mag_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {fl_q, rd_q, rn_q};

  `include "rational_arithmetic_unit_macros.svh"

  `RAU_ASSERT_IMPL(a_out_not_ready, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `RAU_ASSERT_IMPL(a_div_in_reduce, clk_i, rst_ni, dv_ctrl.busy, (state_q == ST_GCD) || (state_q == ST_DIVS))
  `RAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

`default_nettype wire
